// ===== design/srtf_pkg.sv =====
package srtf_pkg;

	// default geometry
	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 16;

	// fixed widths of the request/result fields
	localparam int FIELD_TIME_W = 16;
	localparam int FIELD_SLOT_W = 4;

	// request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

endpackage

// ===== design/srtf_task_table.sv =====
module srtf_task_table
	import srtf_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int IDX_W    = $clog2(SLOTS)
) (
	input  logic                 clk,
	input  logic                 we_load,
	input  logic                 we_rem,
	input  logic [IDX_W-1:0]     waddr,
	input  logic [TIME_BITS-1:0] w_arr,
	input  logic [TIME_BITS-1:0] w_bur,
	input  logic [TIME_BITS-1:0] w_rem,
	input  logic [IDX_W-1:0]     raddr,
	output logic [TIME_BITS-1:0] r_arr,
	output logic [TIME_BITS-1:0] r_bur,
	output logic [TIME_BITS-1:0] r_rem
);

	logic [TIME_BITS-1:0] arr_mem [SLOTS];
	logic [TIME_BITS-1:0] bur_mem [SLOTS];
	logic [TIME_BITS-1:0] rem_mem [SLOTS];

	// load writes a whole entry; a tick only rewrites remaining time
	always_ff @(posedge clk) begin
		if (we_load) begin
			arr_mem[waddr] <= w_arr;
			bur_mem[waddr] <= w_bur;
		end
		if (we_load || we_rem) begin
			rem_mem[waddr] <= w_rem;
		end
	end

	always_ff @(posedge clk) begin
		r_arr <= arr_mem[raddr];
		r_bur <= bur_mem[raddr];
		r_rem <= rem_mem[raddr];
	end

endmodule

// ===== design/srtf_preemptive_scheduler_core.sv =====
// Preemptive shortest-remaining-time-first scheduler.
//
// Input channel (in_valid / in_stall): one request per item. kind = load puts
// a task (arrival, burst) into the next free slot; kind = tick advances time
// by one unit and runs the arrived, unfinished task with the least remaining
// time (ties: earlier arrival, then lower slot).
// Output channel (out_valid / out_stall): exactly one result per request.
//
// Steps: a load goes straight to the emit step. A tick scans one slot a
// cycle through the table's single registered read port, then the update
// steps share one subtractor: UPD when a task was picked, TAT and WAIT
// when it finishes, then EMIT. The next request can be taken once the
// result has entered the output register. in_stall is high while a
// request is in work.
//
// Reset clears time, slot count, finish marks and the previous choice; the
// task table itself is not cleared, only loaded slots are read.
// A stalled result sits in the output register; the next request is still
// accepted and worked on, and its result waits until the register frees.
module srtf_preemptive_scheduler_core
	import srtf_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [FIELD_TIME_W-1:0] arrival,
	input  logic [FIELD_TIME_W-1:0] burst,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    accepted,
	output logic [FIELD_TIME_W-1:0] tick_time,
	output logic                    idle,
	output logic [FIELD_SLOT_W-1:0] slot,
	output logic                    new_segment,
	output logic                    finished,
	output logic [FIELD_TIME_W-1:0] completion_time,
	output logic [FIELD_TIME_W-1:0] turnaround,
	output logic [FIELD_TIME_W-1:0] waiting,
	output logic                    all_done
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CH_W  = $clog2(SLOTS + 2);
	localparam logic [31:0] TMAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [TIME_BITS-1:0] TMAX = TMAX32[TIME_BITS-1:0];
	localparam logic [CH_W-1:0] CHOICE_IDLE = CH_W'(SLOTS);
	localparam logic [CH_W-1:0] CHOICE_NONE = CH_W'(SLOTS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_UPD  = 6'b000100,
		ST_TAT  = 6'b001000,
		ST_WAIT = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	// saturate a 16-bit field into the time range
	function automatic logic [TIME_BITS-1:0] clamp_time(input logic [FIELD_TIME_W-1:0] v);
		logic [31:0] e;
		e = 32'(v);
		return (e > TMAX32) ? TMAX : e[TIME_BITS-1:0];
	endfunction

	// keep the low bits of a time value for a result field
	function automatic logic [FIELD_TIME_W-1:0] to_field(input logic [TIME_BITS-1:0] t);
		logic [31:0] e;
		e = 32'(t);
		return e[FIELD_TIME_W-1:0];
	endfunction

	state_t state_q;

	// scheduler state
	logic [TIME_BITS-1:0] now_q;
	logic [SLOTS-1:0]     fin_q;
	logic [CNT_W-1:0]     loaded_q;
	logic [CNT_W-1:0]     done_cnt_q;
	logic [CH_W-1:0]      prev_choice_q;
	logic                 started_q;

	// scan
	logic [CNT_W-1:0]     scan_cnt_q;
	logic                 scan_vld_q;
	logic [IDX_W-1:0]     scan_idx_q;
	logic                 have_q;
	logic [IDX_W-1:0]     best_slot_q;
	logic [TIME_BITS-1:0] best_rem_q;
	logic [TIME_BITS-1:0] best_arr_q;
	logic [TIME_BITS-1:0] best_bur_q;
	logic [TIME_BITS-1:0] tat_q;

	// result being built
	logic                 res_acc_q;
	logic [TIME_BITS-1:0] res_tick_q;
	logic                 res_idle_q;
	logic [IDX_W-1:0]     res_slot_q;
	logic                 res_seg_q;
	logic                 res_fin_q;
	logic [TIME_BITS-1:0] res_comp_q;
	logic [TIME_BITS-1:0] res_tat_q;
	logic [TIME_BITS-1:0] res_wait_q;

	// table port
	logic                 tbl_we_load;
	logic                 tbl_we_rem;
	logic [IDX_W-1:0]     tbl_waddr;
	logic [TIME_BITS-1:0] tbl_w_arr;
	logic [TIME_BITS-1:0] tbl_w_bur;
	logic [TIME_BITS-1:0] tbl_w_rem;
	logic [TIME_BITS-1:0] tbl_r_arr;
	logic [TIME_BITS-1:0] tbl_r_bur;
	logic [TIME_BITS-1:0] tbl_r_rem;

	// shared subtractor: decrement, turnaround, waiting
	logic [TIME_BITS-1:0] sub_a;
	logic [TIME_BITS-1:0] sub_b;
	logic [TIME_BITS:0]   sub_res;
	logic                 sub_borrow;

	logic in_acc;
	logic load_ok;
	logic cand_ok;
	logic cand_better;
	logic scan_done;
	logic out_free;
	logic [CH_W-1:0] pick_code;
	logic [TIME_BITS-1:0] new_rem;
	logic [31:0] slot_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_ok  = !started_q && (loaded_q < CNT_W'(SLOTS));
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		case (state_q)
			ST_TAT: begin
				sub_a = now_q;
				sub_b = best_arr_q;
			end
			ST_WAIT: begin
				sub_a = tat_q;
				sub_b = best_bur_q;
			end
			default: begin
				sub_a = best_rem_q;
				sub_b = TIME_BITS'(1);
			end
		endcase
	end

	assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_borrow = sub_res[TIME_BITS];
	// zero-burst task stays at zero
	assign new_rem    = (best_rem_q == '0) ? '0 : sub_res[TIME_BITS-1:0];

	// candidate from the previous cycle's read
	assign cand_ok = scan_vld_q && !fin_q[scan_idx_q] && (tbl_r_arr <= now_q);
	assign cand_better = !have_q || (tbl_r_rem < best_rem_q) ||
		((tbl_r_rem == best_rem_q) && (tbl_r_arr < best_arr_q));
	assign scan_done = !scan_vld_q && (scan_cnt_q == loaded_q);
	assign pick_code = have_q ? CH_W'(best_slot_q) : CHOICE_IDLE;

	// table write: loads at the fill index, ticks at the picked slot
	assign tbl_we_load = in_acc && (kind == KIND_LOAD) && load_ok;
	assign tbl_we_rem  = (state_q == ST_UPD);
	assign tbl_waddr   = (state_q == ST_UPD) ? best_slot_q : loaded_q[IDX_W-1:0];
	assign tbl_w_arr   = clamp_time(arrival);
	assign tbl_w_bur   = clamp_time(burst);
	assign tbl_w_rem   = (state_q == ST_UPD) ? new_rem : clamp_time(burst);

	srtf_task_table #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_table (
		.clk     (clk),
		.we_load (tbl_we_load),
		.we_rem  (tbl_we_rem),
		.waddr   (tbl_waddr),
		.w_arr   (tbl_w_arr),
		.w_bur   (tbl_w_bur),
		.w_rem   (tbl_w_rem),
		.raddr   (scan_cnt_q[IDX_W-1:0]),
		.r_arr   (tbl_r_arr),
		.r_bur   (tbl_r_bur),
		.r_rem   (tbl_r_rem)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			now_q         <= '0;
			fin_q         <= '0;
			loaded_q      <= '0;
			done_cnt_q    <= '0;
			prev_choice_q <= CHOICE_NONE;
			started_q     <= 1'b0;
			scan_cnt_q    <= '0;
			scan_vld_q    <= 1'b0;
			have_q        <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (kind == KIND_LOAD) begin
							if (load_ok) begin
								fin_q[loaded_q[IDX_W-1:0]] <= 1'b0;
								loaded_q <= loaded_q + 1'b1;
							end
							state_q <= ST_EMIT;
						end else begin
							started_q  <= 1'b1;
							scan_cnt_q <= '0;
							scan_vld_q <= 1'b0;
							have_q     <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// one slot read issued per cycle, compared the next
					if (cand_ok && cand_better) begin
						have_q <= 1'b1;
					end
					if (scan_cnt_q != loaded_q) begin
						scan_vld_q <= 1'b1;
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end else begin
						scan_vld_q <= 1'b0;
					end
					if (scan_done) begin
						prev_choice_q <= pick_code;
						if (now_q != TMAX) begin
							now_q <= now_q + 1'b1;
						end
						state_q <= have_q ? ST_UPD : ST_EMIT;
					end
				end
				ST_UPD: begin
					if (new_rem == '0) begin
						fin_q[best_slot_q] <= 1'b1;
						done_cnt_q <= done_cnt_q + 1'b1;
						state_q <= ST_TAT;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_TAT: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		scan_idx_q <= scan_cnt_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				res_acc_q  <= in_acc && (kind == KIND_LOAD) && load_ok;
				res_tick_q <= (in_acc && (kind == KIND_TICK)) ? now_q : '0;
				res_idle_q <= 1'b0;
				res_slot_q <= (in_acc && (kind == KIND_LOAD) && load_ok) ?
					loaded_q[IDX_W-1:0] : '0;
				res_seg_q  <= 1'b0;
				res_fin_q  <= 1'b0;
				res_comp_q <= '0;
				res_tat_q  <= '0;
				res_wait_q <= '0;
			end
			ST_SCAN: begin
				if (cand_ok && cand_better) begin
					best_slot_q <= scan_idx_q;
					best_rem_q  <= tbl_r_rem;
					best_arr_q  <= tbl_r_arr;
					best_bur_q  <= tbl_r_bur;
				end
				if (scan_done) begin
					res_seg_q  <= (pick_code != prev_choice_q);
					res_idle_q <= !have_q;
					if (have_q) begin
						res_slot_q <= best_slot_q;
					end
				end
			end
			ST_UPD: begin
				if (new_rem == '0) begin
					res_fin_q  <= 1'b1;
					res_comp_q <= now_q;
				end
			end
			ST_TAT: begin
				tat_q     <= sub_res[TIME_BITS-1:0];
				res_tat_q <= sub_res[TIME_BITS-1:0];
			end
			ST_WAIT: begin
				// floored at zero once time has saturated
				res_wait_q <= sub_borrow ? '0 : sub_res[TIME_BITS-1:0];
			end
			default: begin
			end
		endcase
	end

	assign slot_ext = 32'(res_slot_q);

	// output register
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			accepted        <= res_acc_q;
			tick_time       <= to_field(res_tick_q);
			idle            <= res_idle_q;
			slot            <= slot_ext[FIELD_SLOT_W-1:0];
			new_segment     <= res_seg_q;
			finished        <= res_fin_q;
			completion_time <= to_field(res_comp_q);
			turnaround      <= to_field(res_tat_q);
			waiting         <= to_field(res_wait_q);
			all_done        <= (done_cnt_q == loaded_q);
		end
	end

endmodule

// ===== tb/sv/tb_srtf_preemptive_scheduler_core.sv =====
module tb_srtf_preemptive_scheduler_core;
	import srtf_pkg::*;

	localparam int NSLOTS      = SLOTS_DEF;
	localparam int CHOICE_IDLE = NSLOTS;       // idle tick counts as a choice
	localparam int CHOICE_NONE = NSLOTS + 1;   // nothing chosen yet
	localparam int IDLE_PCT    = 22;

	// one request on the input channel
	typedef struct packed {
		logic                    drain;   // hold off until every outcome is back
		logic                    op;
		logic [FIELD_TIME_W-1:0] arr;
		logic [FIELD_TIME_W-1:0] dur;
	} sched_request_t;

	// one result on the output channel
	typedef struct packed {
		logic                    accepted;
		logic [FIELD_TIME_W-1:0] tick_time;
		logic                    idle;
		logic [FIELD_SLOT_W-1:0] slot;
		logic                    new_segment;
		logic                    finished;
		logic [FIELD_TIME_W-1:0] completion_time;
		logic [FIELD_TIME_W-1:0] turnaround;
		logic [FIELD_TIME_W-1:0] waiting;
		logic                    all_done;
	} sched_outcome_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    kind = KIND_LOAD;
	logic [FIELD_TIME_W-1:0] arrival = '0;
	logic [FIELD_TIME_W-1:0] burst = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    accepted;
	logic [FIELD_TIME_W-1:0] tick_time;
	logic                    idle;
	logic [FIELD_SLOT_W-1:0] slot;
	logic                    new_segment;
	logic                    finished;
	logic [FIELD_TIME_W-1:0] completion_time;
	logic [FIELD_TIME_W-1:0] turnaround;
	logic [FIELD_TIME_W-1:0] waiting;
	logic                    all_done;

	srtf_preemptive_scheduler_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.arrival         (arrival),
		.burst           (burst),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.tick_time       (tick_time),
		.idle            (idle),
		.slot            (slot),
		.new_segment     (new_segment),
		.finished        (finished),
		.completion_time (completion_time),
		.turnaround      (turnaround),
		.waiting         (waiting),
		.all_done        (all_done)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// requests waiting to go out, and outcomes predicted but not yet seen
	sched_request_t request_fifo[$];
	sched_outcome_t outcome_fifo[$];

	// shadow of the scheduler state
	logic [FIELD_TIME_W-1:0] sched_now;
	logic [FIELD_TIME_W-1:0] arr_tab  [NSLOTS];
	logic [FIELD_TIME_W-1:0] dur_tab  [NSLOTS];
	logic [FIELD_TIME_W-1:0] rem_tab  [NSLOTS];
	logic                    done_tab [NSLOTS];
	int                      n_loaded;
	int                      n_finished;
	int                      prev_choice;
	logic                    started;

	// run statistics
	int loads_taken, loads_refused, ticks_run, ticks_idle, completions, preemptions;
	int requests_sent, outcomes_seen, mismatches;

	// driver scratch
	logic           req_taken;
	logic           calm_send;
	sched_request_t req_now;
	sched_outcome_t want;

	// One scheduler step: load into the next slot, or pick the shortest
	// remaining arrived task and run it for one unit. Queues the outcome.
	task automatic schedule_step(input logic op, input logic [FIELD_TIME_W-1:0] arr,
			input logic [FIELD_TIME_W-1:0] dur);
		sched_outcome_t          r;
		int                      pick;
		logic [FIELD_TIME_W-1:0] tat;
		r = '0;
		if (op == KIND_LOAD) begin
			// refused once time has started or the table is full
			if (!started && n_loaded < NSLOTS) begin
				arr_tab[n_loaded]  = arr;
				dur_tab[n_loaded]  = dur;
				rem_tab[n_loaded]  = dur;
				done_tab[n_loaded] = 1'b0;
				r.accepted = 1'b1;
				r.slot     = n_loaded[FIELD_SLOT_W-1:0];
				n_loaded++;
				loads_taken++;
			end else begin
				loads_refused++;
			end
		end else begin
			started     = 1'b1;
			r.tick_time = sched_now;
			pick        = CHOICE_IDLE;
			for (int i = 0; i < n_loaded; i++) begin
				if (!done_tab[i] && arr_tab[i] <= sched_now) begin
					// ties: earlier arrival, then lower slot (scan order)
					if (pick == CHOICE_IDLE || rem_tab[i] < rem_tab[pick] ||
							(rem_tab[i] == rem_tab[pick] && arr_tab[i] < arr_tab[pick]))
						pick = i;
				end
			end
			r.new_segment = (pick != prev_choice);
			if (r.new_segment && prev_choice < NSLOTS && pick < NSLOTS &&
					!done_tab[prev_choice])
				preemptions++;
			prev_choice = pick;
			if (sched_now != '1)
				sched_now++;   // time saturates
			ticks_run++;
			if (pick == CHOICE_IDLE) begin
				r.idle = 1'b1;
				ticks_idle++;
			end else begin
				r.slot = pick[FIELD_SLOT_W-1:0];
				if (rem_tab[pick] != '0)
					rem_tab[pick]--;
				if (rem_tab[pick] == '0) begin
					tat = sched_now - arr_tab[pick];
					done_tab[pick]    = 1'b1;
					n_finished++;
					completions++;
					r.finished        = 1'b1;
					r.completion_time = sched_now;
					r.turnaround      = tat;
					r.waiting         = (tat > dur_tab[pick]) ? tat - dur_tab[pick] : '0;
				end
			end
		end
		r.all_done = (n_finished == n_loaded);
		outcome_fifo = {outcome_fifo, r};
	endtask

	task automatic report_mismatch(input string what, input logic [FIELD_TIME_W-1:0] got,
			input logic [FIELD_TIME_W-1:0] exp_val);
		$display("MISMATCH result %0d: %s got %0h expected %0h", outcomes_seen, what, got,
			exp_val);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [FIELD_TIME_W-1:0] got,
			input logic [FIELD_TIME_W-1:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	task automatic queue_request(input logic drain, input logic op,
			input logic [FIELD_TIME_W-1:0] arr, input logic [FIELD_TIME_W-1:0] dur);
		sched_request_t q;
		q.drain = drain;
		q.op    = op;
		q.arr   = arr;
		q.dur   = dur;
		request_fifo = {request_fifo, q};
	endtask

	// Driver: a request is taken on an edge with in_valid high and in_stall
	// low; that edge is also where the shadow model steps. Payload holds
	// while stalled. Random gaps, except for a calm window mid-run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= KIND_LOAD;
			arrival  <= '0;
			burst    <= '0;
		end else begin
			req_taken = in_valid && !in_stall;
			if (req_taken) begin
				schedule_step(kind, arrival, burst);
				requests_sent++;
			end
			calm_send = (requests_sent >= 290 && requests_sent < 420);
			if (!in_valid || req_taken) begin
				if (request_fifo.size() != 0 &&
						!(request_fifo[0].drain && outcome_fifo.size() != 0) &&
						(calm_send || $urandom_range(99) >= IDLE_PCT)) begin
					req_now = request_fifo.pop_front();
					in_valid <= 1'b1;
					kind     <= req_now.op;
					arrival  <= req_now.arr;
					burst    <= req_now.dur;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result with the oldest prediction, and
	// stall at random outside its own calm window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (outcome_fifo.size() == 0) begin
					report_mismatch("unexpected result, slot", FIELD_TIME_W'(slot), '0);
				end else begin
					want = outcome_fifo.pop_front();
					check_field("accepted", FIELD_TIME_W'(accepted),
						FIELD_TIME_W'(want.accepted));
					check_field("tick_time", tick_time, want.tick_time);
					check_field("idle", FIELD_TIME_W'(idle), FIELD_TIME_W'(want.idle));
					check_field("slot", FIELD_TIME_W'(slot), FIELD_TIME_W'(want.slot));
					check_field("new_segment", FIELD_TIME_W'(new_segment),
						FIELD_TIME_W'(want.new_segment));
					check_field("finished", FIELD_TIME_W'(finished),
						FIELD_TIME_W'(want.finished));
					check_field("completion_time", completion_time, want.completion_time);
					check_field("turnaround", turnaround, want.turnaround);
					check_field("waiting", waiting, want.waiting);
					check_field("all_done", FIELD_TIME_W'(all_done),
						FIELD_TIME_W'(want.all_done));
				end
				outcomes_seen++;
			end
			if (outcomes_seen >= 300 && outcomes_seen < 430)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Watchdog; a correct run needs well under a tenth of this.
	initial begin
		#10_000_000;
		$display("timeout with %0d requests queued, %0d results outstanding",
			request_fifo.size(), outcome_fifo.size());
		$display("tb_srtf_preemptive_scheduler_core failed");
		$finish;
	end

	initial begin
		int                      horizon;
		int                      max_arr;
		logic [FIELD_TIME_W-1:0] t_arr;
		logic [FIELD_TIME_W-1:0] t_dur;

		sched_now   = '0;
		n_loaded    = 0;
		n_finished  = 0;
		prev_choice = CHOICE_NONE;
		started     = 1'b0;
		for (int i = 0; i < NSLOTS; i++)
			done_tab[i] = 1'b0;

		// Directed table: one-unit job at time zero, a same-arrival same-burst
		// pair (lower slot wins), a shorter arrival that preempts, and an
		// equal-burst later arrival.
		queue_request(1'b0, KIND_LOAD, 16'd0, 16'd1);
		queue_request(1'b0, KIND_LOAD, 16'd0, 16'd5);
		queue_request(1'b0, KIND_LOAD, 16'd0, 16'd5);
		queue_request(1'b0, KIND_LOAD, 16'd2, 16'd3);
		queue_request(1'b0, KIND_LOAD, 16'd3, 16'd3);
		horizon = 1 + 5 + 5 + 3 + 3;
		max_arr = 3;
		// random jobs; one exact duplicate keeps a full tie in play
		for (int i = 5; i < NSLOTS - 1; i++) begin
			if (i != 6) begin
				t_arr = FIELD_TIME_W'($urandom_range(0, 200));
				t_dur = FIELD_TIME_W'($urandom_range(1, 30));
			end
			queue_request(1'b0, KIND_LOAD, t_arr, t_dur);
			horizon += int'(t_dur);
			if (int'(t_arr) > max_arr)
				max_arr = int'(t_arr);
		end
		// last job arrives after everything else is done: forces idle ticks
		t_dur = FIELD_TIME_W'($urandom_range(1, 30));
		queue_request(1'b0, KIND_LOAD,
			FIELD_TIME_W'(horizon + max_arr + int'($urandom_range(5, 30))), t_dur);
		// table full: refused, with the field extremes on the wires
		queue_request(1'b0, KIND_LOAD, 16'hFFFF, 16'hFFFF);
		queue_request(1'b0, KIND_LOAD, 16'h0000, 16'h8000);
		for (int i = 0; i < 4; i++)
			queue_request(1'b0, KIND_TICK, 16'h0000, 16'h0001);
		// after the first tick: refused
		queue_request(1'b0, KIND_LOAD, 16'hAAAA, 16'h5555);

		// Random phase: mostly ticks, which carry the schedule through
		// preemptions, completions, idle stretches and the all-done tail;
		// loads sprinkled in are refused. Drains now and then.
		for (int i = 0; i < 700; i++) begin
			if ($urandom_range(99) < 8)
				queue_request(i % 200 == 0, KIND_LOAD,
					FIELD_TIME_W'($urandom_range(0, 65535)),
					FIELD_TIME_W'($urandom_range(1, 65535)));
			else
				queue_request(i % 200 == 0, KIND_TICK,
					FIELD_TIME_W'($urandom_range(0, 65535)),
					FIELD_TIME_W'($urandom_range(1, 65535)));
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_fifo.size() != 0 || in_valid)
			@(posedge clk);
		while (outcome_fifo.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("run: %0d loads stored, %0d refused; %0d ticks (%0d idle), %0d preemptions",
			loads_taken, loads_refused, ticks_run, ticks_idle, preemptions);
		$display("run: %0d task completions, %0d results checked, %0d mismatches",
			completions, outcomes_seen, mismatches);
		if (mismatches == 0)
			$display("tb_srtf_preemptive_scheduler_core passed");
		else
			$display("tb_srtf_preemptive_scheduler_core failed");
		$finish;
	end

endmodule
